[src/swbc_pkg.sv]
`default_nettype none
package swbc_pkg;

  localparam int MAX_WINDOW_DEF = 4096;

  localparam int BYTE_W = 8;
  localparam int WIN_W  = 13;
  localparam int POS_W  = WIN_W + 1;
  localparam int PHASE_W = 12;
  localparam int PCT_W  = 15;
  localparam int IDX_W  = 16;
  localparam int PROD_W = WIN_W + PCT_W;
  localparam int DIV_STEPS = PCT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [WIN_W-1:0] WINDOW_RESET = 13'd100;
  localparam logic [WIN_W-1:0] STEP_RESET   = 13'd1;
  localparam logic [WIN_W-1:0] STEP_MAX     = 13'd4096;
  localparam logic [PCT_W-1:0] PCT_SCALE    = 15'd25600;

  localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_G = 8'h47;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH   = 2'd2;

  typedef struct packed {
    logic accept;
    logic update;
    logic mul;
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

[src/swbc_ctrl.sv]
`default_nettype none
module swbc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire swbc_pkg::stat_t stat,
  output swbc_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UPDATE = 6'b000010,
    S_MUL    = 6'b000100,
    S_LOAD   = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [swbc_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = stat.emit ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load     = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.step     = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == swbc_pkg::DIV_CNT_W'(swbc_pkg::DIV_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule
`default_nettype wire

[src/swbc_dp.sv]
`default_nettype none
module swbc_dp #(
  parameter int MAX_WINDOW = swbc_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire swbc_pkg::cmd_t                    cmd,
  output swbc_pkg::stat_t                        stat,
  input  wire logic [swbc_pkg::BYTE_W-1:0]       base_byte,
  input  wire logic                              region_end,
  input  wire logic                              cfg_valid,
  input  wire logic [swbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [swbc_pkg::WIN_W-1:0]        cfg_data,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [swbc_pkg::PCT_W-1:0]             content_percent,
  output logic [swbc_pkg::IDX_W-1:0]             window_index
);

  localparam int WW = swbc_pkg::WIN_W;
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PW = (AW + 1 > WW) ? AW + 1 : WW;

  // configuration
  logic              content_mode;
  logic [WW-1:0]     window_length;
  logic [WW-1:0]     step_length;
  logic [WW-1:0]     win;
  logic [WW-1:0]     step;

  // region state
  logic                               ring [MAX_WINDOW];
  logic [AW-1:0]                      ptr;
  logic [WW-1:0]                      count;
  logic [swbc_pkg::POS_W-1:0]         pos;
  logic [swbc_pkg::PHASE_W-1:0]       phase;
  logic [swbc_pkg::IDX_W-1:0]         win_cnt;

  // per-item
  logic                               match_bit;
  logic                               last_bit;
  logic                               rd_bit;
  logic [swbc_pkg::IDX_W-1:0]         win_idx;
  logic [WW-1:0]                      pct_cnt;
  logic [swbc_pkg::PROD_W-1:0]        prod;
  logic [WW-1:0]                      rem;
  logic [swbc_pkg::PCT_W-1:0]         quo;

  logic                               match_in;
  logic                               dec;
  logic [WW:0]                        cnt_sum;
  logic [WW-1:0]                      count_next;
  logic [swbc_pkg::POS_W-1:0]         pos_next;
  logic                               full;
  logic                               first;
  logic                               phase_hit;
  logic                               emit;
  logic [swbc_pkg::PHASE_W-1:0]       phase_next;
  logic [AW-1:0]                      ptr_next;
  logic [WW:0]                        rem_sh;
  logic                               q_bit;
  logic                               cfg_restart;

  always_comb begin
    if (window_length == '0) begin
      win = WW'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      win = WW'(MAX_WINDOW);
    end else begin
      win = window_length;
    end
    if (step_length == '0) begin
      step = WW'(1);
    end else if (step_length > swbc_pkg::STEP_MAX) begin
      step = swbc_pkg::STEP_MAX;
    end else begin
      step = step_length;
    end
  end

  always_comb begin
    if (content_mode) begin
      match_in = (base_byte == swbc_pkg::CHAR_A) || (base_byte == swbc_pkg::CHAR_G);
    end else begin
      match_in = (base_byte == swbc_pkg::CHAR_G) || (base_byte == swbc_pkg::CHAR_C);
    end
  end

  // window update
  always_comb begin
    dec      = (pos >= {1'b0, win}) && rd_bit && (count != '0);
    cnt_sum  = {1'b0, count} - (WW + 1)'(dec) + (WW + 1)'(match_bit);
    count_next = (cnt_sum > {1'b0, win}) ? win : cnt_sum[WW-1:0];
    pos_next = (pos == '1) ? pos : pos + 1'b1;
    full     = pos_next >= {1'b0, win};
    first    = pos_next == {1'b0, win};
    phase_hit = (WW'(phase) + WW'(1)) >= step;
    emit     = full && (first || phase_hit);
    if (!full) begin
      phase_next = phase;
    end else if (emit) begin
      phase_next = '0;
    end else begin
      phase_next = phase + 1'b1;
    end
    ptr_next = ((PW'(ptr) + PW'(1)) == PW'(win)) ? '0 : ptr + 1'b1;
  end

  // restoring division step
  always_comb begin
    rem_sh = {rem, quo[swbc_pkg::PCT_W-1]};
    q_bit  = rem_sh >= {1'b0, win};
  end

  assign cfg_restart = cfg_valid &&
                       ((cfg_index == swbc_pkg::REG_WINDOW_LENGTH) ||
                        (cfg_index == swbc_pkg::REG_STEP_LENGTH));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_bit <= ring[ptr];
    end
    if (cmd.update) begin
      ring[ptr] <= match_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      content_mode  <= 1'b0;
      window_length <= swbc_pkg::WINDOW_RESET;
      step_length   <= swbc_pkg::STEP_RESET;
      ptr           <= '0;
      count         <= '0;
      pos           <= '0;
      phase         <= '0;
      win_cnt       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          swbc_pkg::REG_CONTENT_MODE:  content_mode  <= cfg_data[0];
          swbc_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data;
          swbc_pkg::REG_STEP_LENGTH:   step_length   <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_restart || (cmd.update && last_bit)) begin
        ptr     <= '0;
        count   <= '0;
        pos     <= '0;
        phase   <= '0;
        win_cnt <= '0;
      end else if (cmd.update) begin
        ptr   <= ptr_next;
        count <= count_next;
        pos   <= pos_next;
        phase <= phase_next;
        if (emit) begin
          win_cnt <= win_cnt + 1'b1;
        end
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      match_bit <= match_in;
      last_bit  <= region_end;
    end
    if (cmd.update) begin
      win_idx <= win_cnt;
      pct_cnt <= count_next;
    end
    if (cmd.mul) begin
      prod <= swbc_pkg::PROD_W'(pct_cnt) * swbc_pkg::PROD_W'(swbc_pkg::PCT_SCALE);
    end
    if (cmd.load) begin
      rem <= prod[swbc_pkg::PROD_W-1:swbc_pkg::PCT_W];
      quo <= prod[swbc_pkg::PCT_W-1:0];
    end else if (cmd.step) begin
      rem <= q_bit ? WW'(rem_sh - {1'b0, win}) : rem_sh[WW-1:0];
      quo <= {quo[swbc_pkg::PCT_W-2:0], q_bit};
    end
    if (cmd.publish) begin
      content_percent <= quo;
      window_index    <= win_idx;
    end
  end

  assign stat.emit     = emit;
  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

[src/sliding_window_base_content.sv]
// Sliding-window base content. Each accepted byte is classed as a match (G or C in
// mode 0, A or G in mode 1, uppercase only) and enters a ring of match bits kept in
// a MAX_WINDOW x 1 memory. Once a region holds window_length bytes, and then every
// step_length bytes, one transaction leaves with count*25600/window_length in
// unsigned 7.8 fixed point and the window number. An item that emits nothing has
// a memory read and update; one that emits also has multiply, operand load, a
// one-bit-per-cycle restoring divider and output load. No byte is taken while an
// item is in work. The finished result sits in an output register, so the next
// byte is taken while it waits. region_end restarts the region after its byte;
// writing window_length or step_length restarts it too. No clearing pass is needed.
`default_nettype none
module sliding_window_base_content #(
  parameter int MAX_WINDOW = swbc_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [swbc_pkg::BYTE_W-1:0]       base_byte,
  input  wire logic                              region_end,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [swbc_pkg::PCT_W-1:0]             content_percent,
  output logic [swbc_pkg::IDX_W-1:0]             window_index,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [swbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [swbc_pkg::WIN_W-1:0]        cfg_data
);

  swbc_pkg::cmd_t  cmd;
  swbc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  swbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swbc_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .base_byte       (base_byte),
    .region_end      (region_end),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .content_percent (content_percent),
    .window_index    (window_index)
  );

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (content_percent <= swbc_pkg::PCT_SCALE))
    else $error("content_percent above full scale");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_publish_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("controller not idle after result load");

endmodule
`default_nettype wire
